// ===== hdl/qsrp_pkg.sv =====
// ----------------------------------------------------------------------------
// qsrp_pkg
// Shared types and constants of the quad stepper ramp pulse generator.
// ----------------------------------------------------------------------------
package qsrp_pkg;

   localparam int DELAY_W     = 16;
   localparam int RAMP_W      = 10;
   localparam int POS_W       = 8;
   localparam int STAGE_W     = 3;
   localparam int STAGE_COUNT = 5;
   localparam int LINE_COUNT  = 4;
   localparam int CSR_ADDR_W  = 5;
   localparam int CSR_DATA_W  = 32;

   localparam logic [STAGE_W-1:0] STAGE_START         = 3'd0;
   localparam logic [STAGE_W-1:0] STAGE_QUARTER       = 3'd1;
   localparam logic [STAGE_W-1:0] STAGE_HALF          = 3'd2;
   localparam logic [STAGE_W-1:0] STAGE_THREE_QUARTER = 3'd3;
   localparam logic [STAGE_W-1:0] STAGE_FULL          = 3'd4;

   localparam logic [1:0] MODE_TICK      = 2'd0;
   localparam logic [1:0] MODE_POWER     = 2'd1;
   localparam logic [1:0] MODE_DIRECTION = 2'd2;

   localparam logic [2:0] REG_DELAY_START         = 3'd0;
   localparam logic [2:0] REG_DELAY_QUARTER       = 3'd1;
   localparam logic [2:0] REG_DELAY_HALF          = 3'd2;
   localparam logic [2:0] REG_DELAY_THREE_QUARTER = 3'd3;
   localparam logic [2:0] REG_DELAY_FULL          = 3'd4;

   localparam logic [DELAY_W-1:0] DELAY_START_RESET         = 16'd2000;
   localparam logic [DELAY_W-1:0] DELAY_QUARTER_RESET       = 16'd1500;
   localparam logic [DELAY_W-1:0] DELAY_HALF_RESET          = 16'd1000;
   localparam logic [DELAY_W-1:0] DELAY_THREE_QUARTER_RESET = 16'd750;
   localparam logic [DELAY_W-1:0] DELAY_FULL_RESET          = 16'd500;

   localparam logic [RAMP_W-1:0]  RAMP_MAX  = 10'd1023;
   localparam logic [DELAY_W-1:0] SINCE_MAX = 16'hFFFF;

   localparam logic [RAMP_W-1:0] RAMP_T1 = 10'd125;
   localparam logic [RAMP_W-1:0] RAMP_T2 = 10'd250;
   localparam logic [RAMP_W-1:0] RAMP_T3 = 10'd375;
   localparam logic [RAMP_W-1:0] RAMP_T4 = 10'd500;
   localparam logic [RAMP_W-1:0] REV_T1  = 10'd100;
   localparam logic [RAMP_W-1:0] REV_T2  = 10'd200;
   localparam logic [RAMP_W-1:0] REV_T3  = 10'd300;

   typedef logic [STAGE_COUNT-1:0][DELAY_W-1:0] delay_set_type;

   typedef struct packed {
      logic tick;
      logic milli;
      logic power;
      logic direction;
      logic level;
   } motor_cmd_type;

   typedef struct packed {
      logic             step;
      logic             disabled;
      logic             direction;
      logic [POS_W-1:0] position;
   } motor_status_type;

endpackage

// ===== hdl/qsrp_req_if.sv =====
// ----------------------------------------------------------------------------
// qsrp_req_if
// Input channel: tick or motor command word.
// ----------------------------------------------------------------------------
interface qsrp_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] mode;
   logic [2:0] motor_index;
   logic       level;

   modport source (output valid, mode, motor_index, level, input ready);
   modport sink   (input valid, mode, motor_index, level, output ready);
endinterface

// ===== hdl/qsrp_rsp_if.sv =====
// ----------------------------------------------------------------------------
// qsrp_rsp_if
// Result channel: line levels and positions after each word.
// ----------------------------------------------------------------------------
interface qsrp_rsp_if;
   logic       valid;
   logic       ready;
   logic [3:0] step_lines;
   logic [3:0] disable_lines;
   logic [3:0] direction_lines;
   logic [7:0] position_one;
   logic [7:0] position_two;
   logic [7:0] position_three;
   logic [7:0] position_four;

   modport source (output valid, step_lines, disable_lines, direction_lines,
                   position_one, position_two, position_three, position_four,
                   input ready);
   modport sink   (input valid, step_lines, disable_lines, direction_lines,
                   position_one, position_two, position_three, position_four,
                   output ready);
endinterface

// ===== hdl/quad_stepper_ramp_pulse_generator.sv =====
// ----------------------------------------------------------------------------
// quad_stepper_ramp_pulse_generator
// Multi-channel stepper step pulse generator with speed ramps.
// Result path: accepted word held in input reg, line levels captured in result reg.
// Throughput: one word per cycle while the result channel is not stalled; state updates once per word.
// Reset: synchronous; delays return to defaults, all motors idle and disabled.
// ----------------------------------------------------------------------------
module quad_stepper_ramp_pulse_generator
   import qsrp_pkg::*;
#(
   parameter int MOTOR_COUNT     = 4,
   parameter int TICKS_PER_MILLI = 1000,
   parameter int STEPS_PER_TURN  = 200
)
(
   input  logic                  clock,
   input  logic                  reset,
   qsrp_req_if.sink              req_chan,
   qsrp_rsp_if.source            rsp_chan,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int PRE_W = (TICKS_PER_MILLI > 1) ? $clog2(TICKS_PER_MILLI) : 1;

   delay_set_type    delays;
   motor_cmd_type    cmd    [MOTOR_COUNT];
   motor_status_type status [MOTOR_COUNT];

   logic             in_valid_ff;
   logic [1:0]       mode_ff;
   logic [2:0]       index_ff;
   logic             level_ff;
   logic             out_valid_ff;
   logic             advance;
   logic             is_tick;
   logic             milli;
   logic             index_ok;
   logic [PRE_W-1:0] pre_ff, pre_in;
   logic [PRE_W:0]   pre_inc;

   logic [LINE_COUNT-1:0] step_in, dis_in, dir_in;
   logic [LINE_COUNT-1:0][POS_W-1:0] pos_in;
   logic [LINE_COUNT-1:0] step_ff, dis_ff, dir_ff;
   logic [LINE_COUNT-1:0][POS_W-1:0] pos_ff;

   qsrp_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .delays      (delays)
   );

   assign advance        = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready && req_chan.valid) begin
         mode_ff  <= req_chan.mode;
         index_ff <= req_chan.motor_index;
         level_ff <= req_chan.level;
      end
   end

   assign is_tick  = advance && (mode_ff == MODE_TICK);
   assign index_ok = (index_ff != 3'd0) && ({1'b0, index_ff} <= 4'(MOTOR_COUNT));
   assign pre_inc  = {1'b0, pre_ff} + (PRE_W+1)'(1);
   assign milli    = pre_inc >= (PRE_W+1)'(TICKS_PER_MILLI);

   always_comb begin
      pre_in = pre_ff;
      if (is_tick) begin
         pre_in = milli ? '0 : pre_inc[PRE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pre_ff <= '0;
      end else begin
         pre_ff <= pre_in;
      end
   end

   for (genvar m = 0; m < MOTOR_COUNT; m++) begin : g_motor
      logic hit;
      assign hit = advance && index_ok && (index_ff == 3'(m + 1));
      assign cmd[m].tick      = is_tick;
      assign cmd[m].milli     = milli;
      assign cmd[m].power     = hit && (mode_ff == MODE_POWER);
      assign cmd[m].direction = hit && (mode_ff == MODE_DIRECTION);
      assign cmd[m].level     = level_ff;

      qsrp_motor #(
         .STEPS_PER_TURN (STEPS_PER_TURN)
      ) u_motor (
         .clock       (clock),
         .reset       (reset),
         .cmd         (cmd[m]),
         .delays      (delays),
         .status_next (status[m])
      );
   end

   for (genvar k = 0; k < LINE_COUNT; k++) begin : g_line
      if (k < MOTOR_COUNT) begin : g_used
         assign step_in[k] = status[k].step;
         assign dis_in[k]  = status[k].disabled;
         assign dir_in[k]  = status[k].direction;
         assign pos_in[k]  = status[k].position;
      end else begin : g_unused
         assign step_in[k] = 1'b0;
         assign dis_in[k]  = 1'b0;
         assign dir_in[k]  = 1'b0;
         assign pos_in[k]  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         step_ff <= step_in;
         dis_ff  <= dis_in;
         dir_ff  <= dir_in;
         pos_ff  <= pos_in;
      end
   end

   assign rsp_chan.valid           = out_valid_ff;
   assign rsp_chan.step_lines      = step_ff;
   assign rsp_chan.disable_lines   = dis_ff;
   assign rsp_chan.direction_lines = dir_ff;
   assign rsp_chan.position_one    = pos_ff[0];
   assign rsp_chan.position_two    = pos_ff[1];
   assign rsp_chan.position_three  = pos_ff[2];
   assign rsp_chan.position_four   = pos_ff[3];

endmodule

// ===== hdl/qsrp_csr.sv =====
// ----------------------------------------------------------------------------
// qsrp_csr
// APB register file holding the five half-period delays.
// ----------------------------------------------------------------------------
module qsrp_csr
   import qsrp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output delay_set_type         delays
);

   delay_set_type delays_ff;
   delay_set_type delays_in;
   logic [2:0]    index;
   logic          wr_en;

   assign index      = csr_paddr[4:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign delays     = delays_ff;

   always_comb begin
      delays_in = delays_ff;
      if (wr_en) begin
         case (index)
            REG_DELAY_START:         delays_in[0] = csr_pwdata[DELAY_W-1:0];
            REG_DELAY_QUARTER:       delays_in[1] = csr_pwdata[DELAY_W-1:0];
            REG_DELAY_HALF:          delays_in[2] = csr_pwdata[DELAY_W-1:0];
            REG_DELAY_THREE_QUARTER: delays_in[3] = csr_pwdata[DELAY_W-1:0];
            REG_DELAY_FULL:          delays_in[4] = csr_pwdata[DELAY_W-1:0];
            default:                 delays_in = delays_ff;
         endcase
      end
   end

   always_comb begin
      case (index)
         REG_DELAY_START:         csr_prdata = {16'd0, delays_ff[0]};
         REG_DELAY_QUARTER:       csr_prdata = {16'd0, delays_ff[1]};
         REG_DELAY_HALF:          csr_prdata = {16'd0, delays_ff[2]};
         REG_DELAY_THREE_QUARTER: csr_prdata = {16'd0, delays_ff[3]};
         REG_DELAY_FULL:          csr_prdata = {16'd0, delays_ff[4]};
         default:                 csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         delays_ff[0] <= DELAY_START_RESET;
         delays_ff[1] <= DELAY_QUARTER_RESET;
         delays_ff[2] <= DELAY_HALF_RESET;
         delays_ff[3] <= DELAY_THREE_QUARTER_RESET;
         delays_ff[4] <= DELAY_FULL_RESET;
      end else begin
         delays_ff <= delays_in;
      end
   end

endmodule

// ===== hdl/qsrp_motor.sv =====
// ----------------------------------------------------------------------------
// qsrp_motor
// One stepper channel: ramp timer, speed stage, step toggling and position.
// ----------------------------------------------------------------------------
module qsrp_motor
   import qsrp_pkg::*;
#(
   parameter int STEPS_PER_TURN = 200
)
(
   input  logic             clock,
   input  logic             reset,
   input  motor_cmd_type    cmd,
   input  delay_set_type    delays,
   output motor_status_type status_next
);

   logic [STAGE_W-1:0] stage_ff,   stage_in;
   logic [RAMP_W-1:0]  ramp_ff,    ramp_in;
   logic [DELAY_W-1:0] since_ff,   since_in;
   logic               run_ff,     run_in;
   logic               stop_ff,    stop_in;
   logic               rev_ff,     rev_in;
   logic               pend_ff,    pend_in;
   logic               step_ff,    step_in;
   logic [POS_W-1:0]   pos_ff,     pos_in;
   logic               dir_ff,     dir_in;
   logic               dis_ff,     dis_in;

   logic [DELAY_W-1:0] cur_delay;
   logic [POS_W-1:0]   pos_inc;

   always_comb begin
      stage_in = stage_ff;
      ramp_in  = ramp_ff;
      since_in = since_ff;
      run_in   = run_ff;
      stop_in  = stop_ff;
      rev_in   = rev_ff;
      pend_in  = pend_ff;
      step_in  = step_ff;
      pos_in   = pos_ff;
      dir_in   = dir_ff;
      dis_in   = dis_ff;
      pos_inc  = pos_ff + POS_W'(1);
      if (cmd.tick) begin
         if (cmd.milli && (ramp_ff != RAMP_MAX)) begin
            ramp_in = ramp_ff + RAMP_W'(1);
         end
         if (stop_ff) begin
            if (ramp_in < RAMP_T1)      stage_in = STAGE_THREE_QUARTER;
            else if (ramp_in < RAMP_T2) stage_in = STAGE_HALF;
            else if (ramp_in < RAMP_T3) stage_in = STAGE_QUARTER;
            else if (ramp_in < RAMP_T4) stage_in = STAGE_START;
            else begin
               stop_in = 1'b0;
               run_in  = 1'b0;
               rev_in  = 1'b0;
               dis_in  = 1'b1;
            end
         end else if (rev_ff) begin
            if (ramp_in < REV_T1)      stage_in = STAGE_THREE_QUARTER;
            else if (ramp_in < REV_T2) stage_in = STAGE_HALF;
            else if (ramp_in < REV_T3) stage_in = STAGE_START;
            else begin
               dir_in  = pend_ff;
               rev_in  = 1'b0;
               ramp_in = '0;
            end
         end else if (run_ff) begin
            if (ramp_in >= RAMP_T4)      stage_in = STAGE_FULL;
            else if (ramp_in >= RAMP_T3) stage_in = STAGE_THREE_QUARTER;
            else if (ramp_in >= RAMP_T2) stage_in = STAGE_HALF;
            else if (ramp_in >= RAMP_T1) stage_in = STAGE_QUARTER;
            else                         stage_in = STAGE_START;
         end else begin
            ramp_in = '0;
         end
         if (since_ff != SINCE_MAX) begin
            since_in = since_ff + DELAY_W'(1);
         end
         if ((run_in || stop_in || rev_in) && (since_in >= cur_delay)) begin
            step_in  = !step_ff;
            since_in = '0;
            if (step_ff) begin
               pos_in = (pos_inc >= POS_W'(STEPS_PER_TURN)) ? '0 : pos_inc;
            end
         end
      end else if (cmd.power) begin
         ramp_in = '0;
         rev_in  = 1'b0;
         if (!cmd.level) begin
            since_in = '0;
            stage_in = STAGE_START;
            run_in   = 1'b1;
            stop_in  = 1'b0;
            pos_in   = '0;
            step_in  = 1'b0;
            dis_in   = 1'b0;
         end else begin
            stop_in = 1'b1;
         end
      end else if (cmd.direction) begin
         if (run_ff && !stop_ff) begin
            ramp_in = '0;
            rev_in  = 1'b1;
            pend_in = cmd.level;
         end else if (!run_ff) begin
            dir_in = cmd.level;
         end
      end
   end

   always_comb begin
      case (stage_in)
         STAGE_START:         cur_delay = delays[0];
         STAGE_QUARTER:       cur_delay = delays[1];
         STAGE_HALF:          cur_delay = delays[2];
         STAGE_THREE_QUARTER: cur_delay = delays[3];
         STAGE_FULL:          cur_delay = delays[4];
         default:             cur_delay = delays[0];
      endcase
   end

   assign status_next.step      = step_in;
   assign status_next.disabled  = dis_in;
   assign status_next.direction = dir_in;
   assign status_next.position  = pos_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= STAGE_START;
         ramp_ff  <= '0;
         since_ff <= '0;
         run_ff   <= 1'b0;
         stop_ff  <= 1'b0;
         rev_ff   <= 1'b0;
         pend_ff  <= 1'b0;
         step_ff  <= 1'b0;
         pos_ff   <= '0;
         dir_ff   <= 1'b1;
         dis_ff   <= 1'b1;
      end else begin
         stage_ff <= stage_in;
         ramp_ff  <= ramp_in;
         since_ff <= since_in;
         run_ff   <= run_in;
         stop_ff  <= stop_in;
         rev_ff   <= rev_in;
         pend_ff  <= pend_in;
         step_ff  <= step_in;
         pos_ff   <= pos_in;
         dir_ff   <= dir_in;
         dis_ff   <= dis_in;
      end
   end

endmodule
